// ===== design/tsvs_pkg.sv =====
// Shared types, constants and helper functions for the touch swipe view selector.
package tsvs_pkg;

  localparam int unsigned ScreenWidth  = 240;
  localparam int unsigned ScreenHeight = 240;
  localparam int unsigned TouchMaxX    = 240;
  localparam int unsigned TouchMaxY    = 240;

  localparam int unsigned CoordW = 10;
  localparam int unsigned ViewW  = 2;
  localparam int unsigned LevelW = 8;

  localparam logic [LevelW-1:0] BacklightFull = LevelW'(250);
  localparam logic [ViewW-1:0]  ViewLast      = ViewW'(3);

  // scaled value = (raw * screen) / touch_max via exact ceiling reciprocal
  localparam int unsigned ProdInW = 2 * CoordW;
  localparam int unsigned ShiftX  = ProdInW + $clog2(TouchMaxX);
  localparam int unsigned ShiftY  = ProdInW + $clog2(TouchMaxY);
  localparam longint unsigned RecipX = ((64'd1 << ShiftX) + TouchMaxX - 1) / TouchMaxX;
  localparam longint unsigned RecipY = ((64'd1 << ShiftY) + TouchMaxY - 1) / TouchMaxY;
  localparam longint unsigned KX = RecipX * ScreenWidth;
  localparam longint unsigned KY = RecipY * ScreenHeight;
  localparam int unsigned ProdXW = ShiftX + CoordW + 1;
  localparam int unsigned ProdYW = ShiftY + CoordW + 1;

  localparam logic [CoordW-1:0] XLow  = CoordW'(ScreenWidth / 2 - ScreenWidth / 10);
  localparam logic [CoordW-1:0] XHigh = CoordW'(ScreenWidth / 2 + ScreenWidth / 10);
  localparam logic [CoordW-1:0] YLow  = CoordW'(ScreenHeight / 2 - ScreenHeight / 10);
  localparam logic [CoordW-1:0] YHigh = CoordW'(ScreenHeight / 2 + ScreenHeight / 10);

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [2:0] {
    GEST_NONE  = 3'd0,
    GEST_LEFT  = 3'd1,
    GEST_RIGHT = 3'd2,
    GEST_DOWN  = 3'd3,
    GEST_UP    = 3'd4
  } gesture_e;

  typedef struct packed {
    logic              touched;
    logic [CoordW-1:0] raw_x;
    logic [CoordW-1:0] raw_y;
    logic              double_tap;
  } poll_t;

  typedef struct packed {
    logic              active;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] last_x;
    logic [CoordW-1:0] last_y;
    logic [ViewW-1:0]  view_mode;
    logic [LevelW-1:0] backlight;
  } state_t;

  typedef struct packed {
    gesture_e          gesture;
    logic [ViewW-1:0]  view_mode;
    logic              view_changed;
    logic              page_prev;
    logic              page_next;
    logic [LevelW-1:0] backlight_level;
  } result_t;

  function automatic logic [CoordW-1:0] scale_x(input logic [CoordW-1:0] raw);
    logic [CoordW-1:0] clamped;
    logic [ProdXW-1:0] prod;
    clamped = (raw > CoordW'(TouchMaxX)) ? CoordW'(TouchMaxX) : raw;
    prod    = ProdXW'(clamped) * ProdXW'(KX);
    return prod[ShiftX +: CoordW];
  endfunction

  function automatic logic [CoordW-1:0] scale_y(input logic [CoordW-1:0] raw);
    logic [CoordW-1:0] clamped;
    logic [ProdYW-1:0] prod;
    clamped = (raw > CoordW'(TouchMaxY)) ? CoordW'(TouchMaxY) : raw;
    prod    = ProdYW'(clamped) * ProdYW'(KY);
    return prod[ShiftY +: CoordW];
  endfunction

endpackage

// ===== design/touch_swipe_view_selector.sv =====
// Top level of the touch swipe view selector with input and result registers.
// Path: a request is captured in the input register, passes the step logic and is held in the result register.
// Throughput: one request per cycle while results are taken; the step logic between the two registers is combinational.
// Stall: a result held on the master side blocks new requests once the input register is full.
// Reset (rst_ni low, asynchronous): pipeline empty, stroke cleared, view 0, backlight 250.
module touch_swipe_view_selector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // touched[0], raw_x[10:1], raw_y[20:11], double_tap[21], zero[23:22]
  input  logic [tsvs_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // gesture[2:0], view_mode[4:3], view_changed[5], page_prev[6], page_next[7],
  // backlight_level[15:8]
  output logic [tsvs_pkg::OutDataW-1:0]   m_axis_tdata
);

  logic              in_v_q;
  tsvs_pkg::poll_t   poll_q;
  logic              out_v_q;
  tsvs_pkg::result_t res_q;
  tsvs_pkg::result_t res_d;
  tsvs_pkg::state_t  state_q;
  tsvs_pkg::state_t  state_d;
  logic              advance;

  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;

  tsvs_step u_step (
    .poll_i   (poll_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q            <= 1'b0;
      out_v_q           <= 1'b0;
      state_q.active    <= 1'b0;
      state_q.start_x   <= '0;
      state_q.start_y   <= '0;
      state_q.last_x    <= '0;
      state_q.last_y    <= '0;
      state_q.view_mode <= '0;
      state_q.backlight <= tsvs_pkg::BacklightFull;
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_v_q <= 1'b1;
        state_q <= state_d;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      poll_q.touched    <= s_axis_tdata[0];
      poll_q.raw_x      <= s_axis_tdata[10:1];
      poll_q.raw_y      <= s_axis_tdata[20:11];
      poll_q.double_tap <= s_axis_tdata[21];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {res_q.backlight_level, res_q.page_next, res_q.page_prev,
                          res_q.view_changed, res_q.view_mode, res_q.gesture};

endmodule

// ===== design/tsvs_step.sv =====
// Per-poll gesture classification and next-state logic.
module tsvs_step (
  input  tsvs_pkg::poll_t   poll_i,
  input  tsvs_pkg::state_t  state_i,
  output tsvs_pkg::state_t  state_o,
  output tsvs_pkg::result_t result_o
);

  logic [tsvs_pkg::CoordW-1:0] px;
  logic [tsvs_pkg::CoordW-1:0] py;
  tsvs_pkg::gesture_e          gest;
  tsvs_pkg::state_t            nxt;
  logic                        changed;

  assign px = tsvs_pkg::scale_x(poll_i.raw_x);
  assign py = tsvs_pkg::scale_y(poll_i.raw_y);

  always_comb begin
    nxt     = state_i;
    gest    = tsvs_pkg::GEST_NONE;
    changed = 1'b0;

    if (poll_i.double_tap) begin
      nxt.backlight = (state_i.backlight != '0) ? '0 : tsvs_pkg::BacklightFull;
    end

    if (poll_i.touched) begin
      if (!state_i.active) begin
        nxt.start_x = px;
        nxt.start_y = py;
        nxt.active  = 1'b1;
      end
      nxt.last_x = px;
      nxt.last_y = py;
    end else if (state_i.active) begin
      if (state_i.last_x < tsvs_pkg::XLow && state_i.start_x > tsvs_pkg::XHigh) begin
        gest = tsvs_pkg::GEST_LEFT;
      end else if (state_i.last_x > tsvs_pkg::XHigh &&
                   state_i.start_x < tsvs_pkg::XLow) begin
        gest = tsvs_pkg::GEST_RIGHT;
      end else if (state_i.last_y > tsvs_pkg::YHigh &&
                   state_i.start_y < tsvs_pkg::YLow) begin
        gest = tsvs_pkg::GEST_DOWN;
      end else if (state_i.last_y < tsvs_pkg::YLow &&
                   state_i.start_y > tsvs_pkg::YHigh) begin
        gest = tsvs_pkg::GEST_UP;
      end
      nxt.active  = 1'b0;
      nxt.start_x = '0;
      nxt.start_y = '0;
      nxt.last_x  = '0;
      nxt.last_y  = '0;
    end

    case (gest)
      tsvs_pkg::GEST_LEFT: begin
        if (state_i.view_mode < tsvs_pkg::ViewLast) begin
          nxt.view_mode = state_i.view_mode + 1'b1;
          changed       = 1'b1;
        end
      end
      tsvs_pkg::GEST_RIGHT: begin
        if (state_i.view_mode != '0) begin
          nxt.view_mode = state_i.view_mode - 1'b1;
          changed       = 1'b1;
        end
      end
      default: begin
      end
    endcase

    state_o                  = nxt;
    result_o.gesture         = gest;
    result_o.view_mode       = nxt.view_mode;
    result_o.view_changed    = changed;
    result_o.page_prev       = (gest == tsvs_pkg::GEST_DOWN);
    result_o.page_next       = (gest == tsvs_pkg::GEST_UP);
    result_o.backlight_level = nxt.backlight;
  end

endmodule

// ===== design/tsvs_checker.sv =====
// Port-level assertion checker for the touch swipe view selector, with its bind.
module tsvs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tsvs_pkg::OutDataW-1:0] m_axis_tdata
);

  logic [2:0] gest;
  assign gest = m_axis_tdata[2:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result request changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5] |->
      gest == tsvs_pkg::GEST_LEFT || gest == tsvs_pkg::GEST_RIGHT)
    else $error("view change without a left or right swipe");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[6] == (gest == tsvs_pkg::GEST_DOWN) &&
                      m_axis_tdata[7] == (gest == tsvs_pkg::GEST_UP))
    else $error("page pulse does not match gesture");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:8] == 8'd0 ||
                      m_axis_tdata[15:8] == tsvs_pkg::BacklightFull)
    else $error("backlight level out of set");

endmodule

bind touch_swipe_view_selector tsvs_checker u_tsvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
